// ----- rtl/core/lcss_pkg.sv -----
package lcss_pkg;

    // Default geometry of the store.
    localparam int SLOTS_DEF  = 64;
    localparam int LEVELS_DEF = 16;

    // Field widths.
    localparam int HANDLE_W = 32;
    localparam int LEVEL_W  = 4;
    localparam int REGION_W = 12;
    localparam int TAG_W    = 24;
    localparam int STATUS_W = 3;

    // Register file of the configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_IDX_REGION_ID = 1'b0;
    localparam logic [REGION_W-1:0] REGION_ID_RST = REGION_W'(1);

    // Command codes.
    localparam logic CMD_ADD     = 1'b0;
    localparam logic CMD_DESTROY = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_ADDED     = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_NULL      = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_DESTROYED = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_EMPTY     = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADD,
        S_WALK
    } seq_state_t;

    // Strobes from the sequencer to the slot memories.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

endpackage

// ----- rtl/core/level_chained_slot_store_core.sv -----
// Add: the result word is registered in the S_ADD state once the result
// register is free, and no new command word is taken before that.
// Destroy: a chain of n slots yields n result words, one per cycle through the
// slot memory read port while the result channel does not stall.
// Reset (aresetn low, synchronous) empties every level and the free list, sets
// the never-used counter to 1 and region_id to 1; slot memories are not cleared.
module level_chained_slot_store_core
    import lcss_pkg::*;
#(
    parameter int SLOTS  = SLOTS_DEF,
    parameter int LEVELS = LEVELS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Command word channel.
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_command,
    input  logic [HANDLE_W-1:0]   s_object_handle,
    input  logic [LEVEL_W-1:0]    s_level,
    // Result word channel.
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [STATUS_W-1:0]   m_status,
    output logic [HANDLE_W-1:0]   m_released_handle,
    output logic [TAG_W-1:0]      m_region_tag,
    output logic                  m_last,
    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int SLOT_AW = $clog2(SLOTS);

    logic [REGION_W-1:0] region_id_reg;
    logic                cfg_wr;

    mem_ctl_t            mem_ctl;
    logic [SLOT_AW-1:0]  mem_rd_addr;
    logic [SLOT_AW-1:0]  mem_wr_addr;
    logic [HANDLE_W-1:0] mem_wr_obj;
    logic [SLOT_AW-1:0]  mem_wr_link;
    logic [HANDLE_W-1:0] mem_rd_obj;
    logic [SLOT_AW-1:0]  mem_rd_link;

    // The port never stalls. Register 0 holds the region id; the byte offset
    // bits are ignored and any other address reads as zero and drops writes.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            region_id_reg <= REGION_ID_RST;
        end else if (cfg_wr && (paddr[2] == REG_IDX_REGION_ID)) begin
            region_id_reg <= pwdata[REGION_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_IDX_REGION_ID) begin
            prdata = APB_DATA_W'(region_id_reg);
        end
    end

    // The sequencer owns the level heads, the free list head and the
    // never-used counter, and reads and writes the slot memories.
    lcss_seq #(
        .SLOTS  (SLOTS),
        .LEVELS (LEVELS)
    ) u_seq (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_object_handle   (s_object_handle),
        .s_level           (s_level),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_released_handle (m_released_handle),
        .m_region_tag      (m_region_tag),
        .m_last            (m_last),
        .region_id         (region_id_reg),
        .mem_ctl           (mem_ctl),
        .mem_rd_addr       (mem_rd_addr),
        .mem_wr_addr       (mem_wr_addr),
        .mem_wr_obj        (mem_wr_obj),
        .mem_wr_link       (mem_wr_link),
        .mem_rd_obj        (mem_rd_obj),
        .mem_rd_link       (mem_rd_link)
    );

    // Stored handles and chain links, one write and one read per cycle.
    lcss_slot_mem #(
        .SLOTS (SLOTS)
    ) u_slot_mem (
        .aclk    (aclk),
        .mem_ctl (mem_ctl),
        .rd_addr (mem_rd_addr),
        .wr_addr (mem_wr_addr),
        .wr_obj  (mem_wr_obj),
        .wr_link (mem_wr_link),
        .rd_obj  (mem_rd_obj),
        .rd_link (mem_rd_link)
    );

endmodule

// ----- rtl/core/lcss_slot_mem.sv -----
module lcss_slot_mem
    import lcss_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                     aclk,
    input  mem_ctl_t                 mem_ctl,
    input  logic [$clog2(SLOTS)-1:0] rd_addr,
    input  logic [$clog2(SLOTS)-1:0] wr_addr,
    input  logic [HANDLE_W-1:0]      wr_obj,
    input  logic [$clog2(SLOTS)-1:0] wr_link,
    output logic [HANDLE_W-1:0]      rd_obj,
    output logic [$clog2(SLOTS)-1:0] rd_link
);

    localparam int SLOT_AW = $clog2(SLOTS);

    logic [HANDLE_W-1:0] obj_mem  [SLOTS];
    logic [SLOT_AW-1:0]  link_mem [SLOTS];

    // Both arrays share one write address and one read address; read data
    // is registered and holds while no read is issued.
    always_ff @(posedge aclk) begin
        if (mem_ctl.wr_en) begin
            obj_mem[wr_addr]  <= wr_obj;
            link_mem[wr_addr] <= wr_link;
        end
        if (mem_ctl.rd_en) begin
            rd_obj  <= obj_mem[rd_addr];
            rd_link <= link_mem[rd_addr];
        end
    end

endmodule

// ----- rtl/core/lcss_seq.sv -----
module lcss_seq
    import lcss_pkg::*;
#(
    parameter int SLOTS  = SLOTS_DEF,
    parameter int LEVELS = LEVELS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_command,
    input  logic [HANDLE_W-1:0]      s_object_handle,
    input  logic [LEVEL_W-1:0]       s_level,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [STATUS_W-1:0]      m_status,
    output logic [HANDLE_W-1:0]      m_released_handle,
    output logic [TAG_W-1:0]         m_region_tag,
    output logic                     m_last,
    input  logic [REGION_W-1:0]      region_id,
    output mem_ctl_t                 mem_ctl,
    output logic [$clog2(SLOTS)-1:0] mem_rd_addr,
    output logic [$clog2(SLOTS)-1:0] mem_wr_addr,
    output logic [HANDLE_W-1:0]      mem_wr_obj,
    output logic [$clog2(SLOTS)-1:0] mem_wr_link,
    input  logic [HANDLE_W-1:0]      mem_rd_obj,
    input  logic [$clog2(SLOTS)-1:0] mem_rd_link
);

    localparam int SLOT_AW    = $clog2(SLOTS);
    localparam int NU_W       = SLOT_AW + 1;
    localparam int LEVEL_CNT  = 2 ** LEVEL_W;
    localparam int HEAD_DEPTH = (LEVELS < LEVEL_CNT) ? LEVELS : LEVEL_CNT;
    localparam int HEAD_AW    = (HEAD_DEPTH > 1) ? $clog2(HEAD_DEPTH) : 1;

    seq_state_t state_reg, state_next;

    logic [SLOT_AW-1:0]  head_reg [HEAD_DEPTH];
    logic [SLOT_AW-1:0]  free_head_reg, free_head_next;
    logic [NU_W-1:0]     nu_reg, nu_next;

    logic [HANDLE_W-1:0] handle_reg;
    logic [LEVEL_W-1:0]  level_reg;
    logic [HEAD_AW-1:0]  li_reg;
    logic [SLOT_AW-1:0]  cur_reg;
    logic [SLOT_AW-1:0]  count_reg;

    logic                m_valid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [HANDLE_W-1:0] m_handle_reg;
    logic [TAG_W-1:0]    m_tag_reg;
    logic                m_last_reg;

    logic [HEAD_AW-1:0]  level_map [LEVEL_CNT];
    logic [HEAD_AW-1:0]  li_in;
    logic [SLOT_AW-1:0]  head_rd;
    logic                accept;
    logic                out_free;

    logic                emit;
    logic [STATUS_W-1:0] o_status;
    logic [HANDLE_W-1:0] o_handle;
    logic [TAG_W-1:0]    o_tag;
    logic                o_last;
    logic                head_we;
    logic [HEAD_AW-1:0]  head_wa;
    logic [SLOT_AW-1:0]  head_wd;
    logic                walk_step;
    logic                walk_done;

    // Level to chain index, folded at elaboration into a constant table.
    for (genvar v = 0; v < LEVEL_CNT; v++) begin : g_level_map
        assign level_map[v] = HEAD_AW'(v % LEVELS);
    end

    assign li_in    = level_map[s_level];
    assign head_rd  = head_reg[li_in];
    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = (s_command == CMD_DESTROY) ? S_WALK : S_ADD;
                end
            end
            S_ADD: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_WALK: begin
                if (walk_done) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        emit           = 1'b0;
        o_status       = STAT_ADDED;
        o_handle       = '0;
        o_tag          = '0;
        o_last         = 1'b0;
        mem_ctl        = '0;
        mem_rd_addr    = free_head_reg;
        mem_wr_addr    = cur_reg;
        mem_wr_obj     = '0;
        mem_wr_link    = free_head_reg;
        head_we        = 1'b0;
        head_wa        = li_reg;
        head_wd        = '0;
        free_head_next = free_head_reg;
        nu_next        = nu_reg;
        walk_step      = 1'b0;
        walk_done      = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    // Fetch the free list successor for an add, or the
                    // first slot of the chain for a destroy.
                    mem_ctl.rd_en = 1'b1;
                    if (s_command == CMD_DESTROY) begin
                        mem_rd_addr = head_rd;
                        head_we     = 1'b1;
                        head_wa     = li_in;
                        head_wd     = '0;
                    end
                end
            end
            S_ADD: begin
                if (out_free) begin
                    emit   = 1'b1;
                    o_last = 1'b1;
                    if (handle_reg == '0) begin
                        o_status = STAT_NULL;
                    end else if (free_head_reg != '0) begin
                        o_status       = STAT_ADDED;
                        head_wd        = free_head_reg;
                        free_head_next = mem_rd_link;
                    end else if (nu_reg < NU_W'(SLOTS)) begin
                        o_status = STAT_ADDED;
                        head_wd  = nu_reg[SLOT_AW-1:0];
                        nu_next  = nu_reg + NU_W'(1);
                    end else begin
                        o_status = STAT_FULL;
                    end
                    if ((handle_reg != '0) && (o_status == STAT_ADDED)) begin
                        mem_ctl.wr_en = 1'b1;
                        mem_wr_addr   = head_wd;
                        mem_wr_obj    = handle_reg;
                        mem_wr_link   = cur_reg;
                        head_we       = 1'b1;
                        head_wa       = li_reg;
                        o_tag         = {region_id, {(REGION_W - LEVEL_W){1'b0}},
                                         level_reg};
                    end
                end
            end
            S_WALK: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (cur_reg == '0) begin
                        o_status  = STAT_EMPTY;
                        o_last    = 1'b1;
                        walk_done = 1'b1;
                    end else begin
                        // Emit this slot, push it on the free list and, unless it is
                        // the last, fetch its successor in the same cycle.
                        o_status       = STAT_DESTROYED;
                        o_handle       = mem_rd_obj;
                        o_last         = (mem_rd_link == '0) ||
                                         (count_reg == SLOT_AW'(SLOTS - 2));
                        walk_step      = 1'b1;
                        walk_done      = o_last;
                        mem_ctl.wr_en  = 1'b1;
                        mem_wr_addr    = cur_reg;
                        mem_wr_obj     = '0;
                        mem_wr_link    = free_head_reg;
                        free_head_next = cur_reg;
                        if (!o_last) begin
                            mem_ctl.rd_en = 1'b1;
                            mem_rd_addr   = mem_rd_link;
                        end
                    end
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            free_head_reg <= '0;
            nu_reg        <= NU_W'(1);
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            nu_reg        <= nu_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < HEAD_DEPTH; i++) begin
                head_reg[i] <= '0;
            end
        end else if (head_we) begin
            head_reg[head_wa] <= head_wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            handle_reg <= s_object_handle;
            level_reg  <= s_level;
            li_reg     <= li_in;
            cur_reg    <= head_rd;
            count_reg  <= '0;
        end else if (walk_step) begin
            cur_reg    <= mem_rd_link;
            count_reg  <= count_reg + SLOT_AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_status_reg <= o_status;
            m_handle_reg <= o_handle;
            m_tag_reg    <= o_tag;
            m_last_reg   <= o_last;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_released_handle = m_handle_reg;
    assign m_region_tag      = m_tag_reg;
    assign m_last            = m_last_reg;

`ifndef NO_ASSERTIONS
    a_nu_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        nu_reg <= NU_W'(SLOTS))
        else $error("never-used counter ran past the store size");

    a_no_rw_same_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_ctl.wr_en && mem_ctl.rd_en) |-> (mem_wr_addr != mem_rd_addr))
        else $error("walk read and write hit the same slot");

    a_add_not_reserved: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ADD && head_we) |-> (head_wd != '0))
        else $error("add linked the reserved slot zero");

    a_destroy_clears_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_command == CMD_DESTROY) |=> (head_reg[$past(li_in)] == '0))
        else $error("destroyed level still has a head");

    a_walk_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WALK) |-> (count_reg < SLOT_AW'(SLOTS - 1)))
        else $error("walk exceeded the slot bound");
`endif

endmodule
